### hw/rtl/psrht_pkg.sv
package psrht_pkg;

  // Item kinds carried on the input channel. The fourth code is unused and
  // leaves the state untouched.
  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_t;

  localparam int KIND_W = 2;

  // Result status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  // Fixed result and register widths.
  localparam int HELD_W   = 11;
  localparam int HITS_W   = 32;
  localparam int RADIUS_W = 36;

  // Register file: one 64-bit register at byte address 8 * index.
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 64;
  localparam int REG_IDX_W = PADDR_W - 3;
  localparam logic [REG_IDX_W-1:0] REG_RADIUS_SQUARED = '0;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 36'd16777216;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the input item, rewind the scan
    logic scan_step;  // read one stored point and advance the scan address
    logic commit;     // apply the item to the state and load the result
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic last_addr;
    logic pipe_empty;
    logic out_busy;
  } dp_status_t;

endpackage

### hw/rtl/psrht_ram.sv
module psrht_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/psrht_ctrl.sv
module psrht_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [1:0]              in_kind,
  input  psrht_pkg::dp_status_t   status,
  output psrht_pkg::ctrl_cmd_t    cmd,
  output logic                    in_stall
);
  import psrht_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_QUERY && !status.count_zero) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (status.last_addr) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.pipe_empty) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_DRAIN: begin
        cmd = '0;
      end
      ST_FINISH: begin
        cmd.commit = !status.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### hw/rtl/psrht_dp.sv
module psrht_dp #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  psrht_pkg::ctrl_cmd_t              cmd,
  output psrht_pkg::dp_status_t             status,
  input  logic [psrht_pkg::KIND_W-1:0]      in_kind,
  input  logic signed [COORD_BITS-1:0]      in_coord_x,
  input  logic signed [COORD_BITS-1:0]      in_coord_y,
  input  logic signed [COORD_BITS-1:0]      in_coord_z,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic                              out_hit,
  output logic [psrht_pkg::HITS_W-1:0]      out_hits_so_far,
  output logic [psrht_pkg::HELD_W-1:0]      out_points_held,
  output logic                              out_status,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [psrht_pkg::PADDR_W-1:0]     paddr,
  input  logic [psrht_pkg::PDATA_W-1:0]     pwdata,
  output logic [psrht_pkg::PDATA_W-1:0]     prdata
);
  import psrht_pkg::*;

  localparam int W    = COORD_BITS;
  localparam int PW   = 3 * W;
  localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int SQW  = 2 * W;
  localparam int SUMW = SQW + 2;
  localparam int CMPW = (SUMW > RADIUS_W) ? SUMW : RADIUS_W;

  // Configuration register.
  logic [RADIUS_W-1:0] radius_r;
  logic                cfg_sel;
  logic                cfg_wr;

  assign cfg_sel = (paddr[PADDR_W-1:3] == REG_RADIUS_SQUARED);
  assign cfg_wr  = psel && penable && pwrite && cfg_sel;
  assign prdata  = cfg_sel ? PDATA_W'(radius_r) : '0;

  // Captured item.
  logic [KIND_W-1:0] kind_r;
  logic [PW-1:0]     query_r;

  // Architectural state.
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [HITS_W-1:0] hits_r;
  logic [HITS_W-1:0] hits_nxt;
  logic              full;

  // Scan pipeline.
  logic [AW-1:0]     addr_r;
  logic              rd_v_r;
  logic              mag_v_r;
  logic              sq_v_r;
  logic              hit_acc_r;
  logic [W-1:0]      mag_r [3];
  logic [W-1:0]      mag_nxt [3];
  logic [SQW-1:0]    sq_r [3];
  logic [SUMW-1:0]   dist_sum;
  logic              in_range;
  logic [PW-1:0]     rdata;

  // Result register.
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_hit_r;
  logic              out_hit_nxt;
  logic              out_status_r;
  logic              out_status_nxt;
  logic [HITS_W-1:0] out_hits_r;
  logic [HELD_W-1:0] out_held_r;

  logic              ram_we;

  assign full = (count_r == CW'(MAX_POINTS));

  assign ram_we = cmd.commit && (kind_r == KIND_APPEND) && !full;

  psrht_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (query_r),
    .raddr (addr_r),
    .rdata (rdata)
  );

  // Per-axis absolute difference between the query and the stored point.
  always_comb begin
    logic [W-1:0] p;
    logic [W-1:0] q;
    logic [W:0]   diff;
    for (int a = 0; a < 3; a++) begin
      p          = rdata[a*W +: W];
      q          = query_r[a*W +: W];
      diff       = {q[W-1], q} - {p[W-1], p};
      mag_nxt[a] = diff[W] ? W'(-diff) : W'(diff);
    end
  end

  assign dist_sum = SUMW'(sq_r[0]) + SUMW'(sq_r[1]) + SUMW'(sq_r[2]);
  assign in_range = (CMPW'(dist_sum) <= CMPW'(radius_r));

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      mag_r[a] <= mag_nxt[a];
      sq_r[a]  <= mag_r[a] * mag_r[a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r    <= 1'b0;
      mag_v_r   <= 1'b0;
      sq_v_r    <= 1'b0;
      hit_acc_r <= 1'b0;
      addr_r    <= '0;
    end else begin
      rd_v_r  <= cmd.scan_step;
      mag_v_r <= rd_v_r;
      sq_v_r  <= mag_v_r;
      if (cmd.capture) begin
        addr_r    <= '0;
        hit_acc_r <= 1'b0;
      end else begin
        if (cmd.scan_step) begin
          addr_r <= addr_r + AW'(1);
        end
        if (sq_v_r && in_range) begin
          hit_acc_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_kind;
      query_r <= {in_coord_x, in_coord_y, in_coord_z};
    end
  end

  // Effect of the captured item on the state and the result fields.
  always_comb begin
    count_nxt      = count_r;
    hits_nxt       = hits_r;
    out_hit_nxt    = 1'b0;
    out_status_nxt = STATUS_OK;
    case (kind_r)
      KIND_CLEAR: begin
        count_nxt = '0;
        hits_nxt  = '0;
      end
      KIND_APPEND: begin
        if (full) begin
          out_status_nxt = STATUS_DROPPED;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      KIND_QUERY: begin
        out_hit_nxt = hit_acc_r;
        if (hit_acc_r && (hits_r != '1)) begin
          hits_nxt = hits_r + HITS_W'(1);
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  assign out_valid_nxt = cmd.commit ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= RADIUS_RESET;
      count_r     <= '0;
      hits_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        radius_r <= pwdata[RADIUS_W-1:0];
      end
      if (cmd.commit) begin
        count_r <= count_nxt;
        hits_r  <= hits_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r    <= out_hit_nxt;
      out_status_r <= out_status_nxt;
      out_hits_r   <= hits_nxt;
      out_held_r   <= HELD_W'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_status      = out_status_r;
  assign out_hits_so_far = out_hits_r;
  assign out_points_held = out_held_r;

  assign status.count_zero = (count_r == '0);
  assign status.last_addr  = ((CW'(addr_r) + CW'(1)) == count_r);
  assign status.pipe_empty = !rd_v_r && !mag_v_r && !sq_v_r;
  assign status.out_busy   = out_valid_r && out_stall;

endmodule

### hw/rtl/point_set_radius_hit_test.sv
// A clear or append item goes from idle straight to the finish state and is committed there
// once the result register is free; for a query the N stored points are first scanned and
// the distance pipeline drained (an empty store skips the scan). One item is taken at a time;
// a query is bound by the single read port of the point RAM, scanned one point per cycle.
// Reset (synchronous, rst_n low): point count and hit counter go to zero, radius_squared to
// 1.0 (16777216); the point RAM is not cleared, since only entries below the count are read.
module point_set_radius_hit_test #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [psrht_pkg::KIND_W-1:0]      in_kind,
  input  logic signed [COORD_BITS-1:0]      in_coord_x,
  input  logic signed [COORD_BITS-1:0]      in_coord_y,
  input  logic signed [COORD_BITS-1:0]      in_coord_z,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  output logic [psrht_pkg::HITS_W-1:0]      out_hits_so_far,
  output logic [psrht_pkg::HELD_W-1:0]      out_points_held,
  output logic                              out_status,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [psrht_pkg::PADDR_W-1:0]     paddr,
  input  logic [psrht_pkg::PDATA_W-1:0]     pwdata,
  output logic [psrht_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready
);
  import psrht_pkg::*;

  // The controller sequences each item: it takes an item in the idle state, walks the
  // stored points for a query, waits for the distance pipeline to empty, and then commits
  // the item once the result register is free. The result register keeps the finished
  // result while the next item is being taken in.
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Every register access completes in its access cycle.
  assign pready = 1'b1;

  psrht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // The datapath holds the point RAM, the point count, the saturating hit counter, the
  // radius register and a three-stage distance pipeline: absolute coordinate difference,
  // squaring, then sum and compare against the squared radius. The comparison is made on
  // the exact sum, so no square root and no rounding is involved.
  psrht_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_kind         (in_kind),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_coord_z      (in_coord_z),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_hits_so_far (out_hits_so_far),
    .out_points_held (out_points_held),
    .out_status      (out_status),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata)
  );

endmodule

### verif/tb_point_set_radius_hit_test.sv
`timescale 1ns / 1ps

// Testbench for the point store radius hit test.
module tb_point_set_radius_hit_test;
  import psrht_pkg::*;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 16;
  // The limit covers a worst-case run, with every random item a query on a store of a few
  // hundred points and long result stalls, with a wide margin.
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 580;
  // The tail covers stray results from a small store.
  localparam int TAIL_CYCLES = 64;

  // The fourth kind code is unused by the block and must leave the state alone.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0] RADIUS_ADDR = {REG_RADIUS_SQUARED, 3'b000};

  // Stall patterns of the result side.
  typedef enum logic [1:0] {
    PACE_FREE,
    PACE_LIGHT,
    PACE_HEAVY,
    PACE_TOGGLE
  } pace_t;

  typedef struct packed {
    logic [KIND_W-1:0]            kind;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } probe_t;

  typedef struct packed {
    logic              hit;
    logic [HITS_W-1:0] hits;
    logic [HELD_W-1:0] held;
    logic              status;
  } verdict_t;

  // Every input starts at a known value.
  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [KIND_W-1:0]            in_kind = '0;
  logic signed [COORD_BITS-1:0] in_coord_x = '0;
  logic signed [COORD_BITS-1:0] in_coord_y = '0;
  logic signed [COORD_BITS-1:0] in_coord_z = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         out_hit;
  logic [HITS_W-1:0]            out_hits_so_far;
  logic [HELD_W-1:0]            out_points_held;
  logic                         out_status;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [PADDR_W-1:0]           paddr = '0;
  logic [PDATA_W-1:0]           pwdata = '0;
  logic [PDATA_W-1:0]           prdata;
  logic                         pready;

  point_set_radius_hit_test #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_hits_so_far(out_hits_so_far),
    .out_points_held(out_points_held),
    .out_status     (out_status),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #10 clk = ~clk;

  // Shadow copy of the block's state, updated at each accepted input transfer.
  logic signed [COORD_BITS-1:0] store_x [MAX_POINTS];
  logic signed [COORD_BITS-1:0] store_y [MAX_POINTS];
  logic signed [COORD_BITS-1:0] store_z [MAX_POINTS];
  int unsigned                  stored_n = 0;
  logic [HITS_W-1:0]            hit_tally = '0;
  logic [RADIUS_W-1:0]          radius_sq = RADIUS_RESET;

  probe_t   pending_items [$];
  verdict_t want_results [$];
  probe_t   on_bus;
  logic     item_on_bus = 1'b0;
  int       mismatches = 0;
  int       cycle_count = 0;

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch: %s", msg);
    end
  endtask

  // Exact squared distance against every stored point. With 16-bit coordinates the sum
  // stays far below the 64-bit range, so no saturation is needed here.
  function automatic logic near_any(input probe_t q);
    longint dx;
    longint dy;
    longint dz;
    longint dist2;
    logic   found;
    found = 1'b0;
    for (int i = 0; i < stored_n; i++) begin
      dx = longint'(q.x) - longint'(store_x[i]);
      dy = longint'(q.y) - longint'(store_y[i]);
      dz = longint'(q.z) - longint'(store_z[i]);
      dist2 = dx * dx + dy * dy + dz * dz;
      if (dist2 <= longint'(radius_sq)) begin
        found = 1'b1;
      end
    end
    return found;
  endfunction

  // Applies one item to the shadow state and returns the result it must produce.
  function automatic verdict_t apply_item(input probe_t it);
    verdict_t v;
    v.hit = 1'b0;
    v.status = STATUS_OK;
    case (it.kind)
      KIND_CLEAR: begin
        stored_n = 0;
        hit_tally = '0;
      end
      KIND_APPEND: begin
        if (stored_n >= MAX_POINTS) begin
          v.status = STATUS_DROPPED;
        end else begin
          store_x[stored_n] = it.x;
          store_y[stored_n] = it.y;
          store_z[stored_n] = it.z;
          stored_n++;
        end
      end
      KIND_QUERY: begin
        if (near_any(it)) begin
          v.hit = 1'b1;
          if (hit_tally != '1) begin
            hit_tally++;
          end
        end
      end
      default: begin
      end
    endcase
    v.hits = hit_tally;
    v.held = HELD_W'(stored_n);
    return v;
  endfunction

  // Input driver. It sends items in bursts of random length with random gaps between them,
  // and holds the payload steady while the block stalls. The prediction is made at the edge
  // where the transfer happens, so config writes between phases see a consistent radius.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        want_results.push_back(apply_item(on_bus));
        item_on_bus = 1'b0;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          on_bus = pending_items.pop_front();
          item_on_bus = 1'b1;
          in_valid <= 1'b1;
          in_kind <= on_bus.kind;
          in_coord_x <= on_bus.x;
          in_coord_y <= on_bus.y;
          in_coord_z <= on_bus.z;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            // About a third of the bursts run straight into the next one.
            gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each accepted result is checked against the oldest expectation. The
  // stall pattern switches between free flow, light and heavy random stalls, and a toggle.
  pace_t stall_pace = PACE_FREE;
  int    stall_left = 0;

  always @(posedge clk) begin
    verdict_t seen;
    verdict_t want;
    seen = {out_hit, out_hits_so_far, out_points_held, out_status};
    if (rst_n && out_valid && !out_stall) begin
      if (want_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result hit=%0b hits=%0d held=%0d status=%0b",
                                seen.hit, seen.hits, seen.held, seen.status));
      end else begin
        want = want_results.pop_front();
        if (seen !== want) begin
          flag_mismatch($sformatf({"expected hit=%0b hits=%0d held=%0d status=%0b, ",
                                   "got hit=%0b hits=%0d held=%0d status=%0b"},
                                  want.hit, want.hits, want.held, want.status,
                                  seen.hit, seen.hits, seen.held, seen.status));
        end
      end
    end
    if (stall_left == 0) begin
      stall_pace = pace_t'($urandom_range(0, 3));
      stall_left = $urandom_range(1, 64);
    end else begin
      stall_left--;
    end
    case (stall_pace)
      PACE_FREE:  out_stall <= 1'b0;
      PACE_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      PACE_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:    out_stall <= ~out_stall;
    endcase
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // One APB transfer: a setup phase, then access until pready is seen high at an edge.
  task automatic apb_access(input logic is_write, input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= RADIUS_ADDR;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Writes the radius register and reads it back. Bits above the register width are dropped.
  task automatic program_radius(input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] back;
    apb_access(1'b1, value, back);
    radius_sq = value[RADIUS_W-1:0];
    apb_access(1'b0, '0, back);
    if (back[RADIUS_W-1:0] !== radius_sq) begin
      flag_mismatch($sformatf("radius read back %0d, expected %0d",
                              back[RADIUS_W-1:0], radius_sq));
    end
  endtask

  // Config writes only happen once every queued item has produced its result.
  task automatic wait_drained();
    while (pending_items.size() != 0 || item_on_bus || want_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic queue_item(input logic [KIND_W-1:0] kind, input int x, input int y,
                            input int z);
    probe_t it;
    it.kind = kind;
    it.x = COORD_BITS'(x);
    it.y = COORD_BITS'(y);
    it.z = COORD_BITS'(z);
    pending_items.push_back(it);
  endtask

  // A coordinate within spread of base, clamped to the Q3.12 range. Clamping piles some
  // values onto the extremes, which is welcome.
  function automatic int nudge(input int base, input int spread);
    int v;
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) begin
      v = 32767;
    end else if (v < -32768) begin
      v = -32768;
    end
    return v;
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  initial begin
    logic [PDATA_W-1:0] reg_back;
    int px [$];
    int py [$];
    int pz [$];
    int random_done;
    int n_app;
    int n_q;
    int pick;
    int spread;
    int q_spread;
    int cx;
    int cy;
    int cz;
    int d;
    logic [PDATA_W-1:0] r_val;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // The radius must come out of reset at 1.0.
    apb_access(1'b0, '0, reg_back);
    if (reg_back[RADIUS_W-1:0] !== RADIUS_RESET) begin
      flag_mismatch($sformatf("radius after reset %0d", reg_back[RADIUS_W-1:0]));
    end

    // Directed part at radius 1.0 (4096 in each axis). A query on the empty store must miss,
    // and the unused kind must only echo the state.
    queue_item(KIND_QUERY, 0, 0, 0);
    queue_item(KIND_UNUSED, any_coord(), any_coord(), any_coord());
    queue_item(KIND_APPEND, 0, 0, 0);
    queue_item(KIND_APPEND, 32767, 32767, 32767);
    queue_item(KIND_APPEND, -32768, -32768, -32768);
    queue_item(KIND_QUERY, 0, 0, 0);
    // Exactly on the sphere hits, one step past it misses.
    queue_item(KIND_QUERY, 4096, 0, 0);
    queue_item(KIND_QUERY, 4097, 0, 0);
    queue_item(KIND_QUERY, 0, -4096, 0);
    queue_item(KIND_QUERY, 32767, -32768, 32767);
    queue_item(KIND_QUERY, -32768, -32768, -32767);
    queue_item(KIND_UNUSED, -1, -1, -1);
    queue_item(KIND_CLEAR, -1, -1, -1);
    queue_item(KIND_QUERY, 0, 0, 0);
    queue_item(KIND_APPEND, 1234, -2345, 3456);
    queue_item(KIND_QUERY, 1234, -2345, 3456);
    wait_drained();

    // A zero radius only hits on an exact match.
    program_radius('0);
    queue_item(KIND_QUERY, 1234, -2345, 3456);
    queue_item(KIND_QUERY, 1235, -2345, 3456);
    queue_item(KIND_QUERY, 1234, -2345, 3455);
    wait_drained();

    // The largest radius, written with junk above bit 35, covers the whole space.
    program_radius({28'hABCDEF1, 36'hF_FFFF_FFFF});
    queue_item(KIND_CLEAR, 0, 0, 0);
    queue_item(KIND_APPEND, -32768, -32768, -32768);
    queue_item(KIND_QUERY, 32767, 32767, 32767);
    wait_drained();

    // Opposite corners are 3 * 65535^2 apart in squared distance: one below that misses, that value hits.
    program_radius(64'd12884508674);
    queue_item(KIND_QUERY, 32767, 32767, 32767);
    wait_drained();
    program_radius(64'd12884508675);
    queue_item(KIND_QUERY, 32767, 32767, 32767);
    wait_drained();

    // Fill the store to capacity. Appends to a full store are dropped with a status, and
    // queries must scan every one of the stored points.
    program_radius(RADIUS_RESET);
    queue_item(KIND_CLEAR, 0, 0, 0);
    px.delete();
    py.delete();
    pz.delete();
    for (int k = 0; k < MAX_POINTS; k++) begin
      px.push_back(any_coord());
      py.push_back(any_coord());
      pz.push_back(any_coord());
      queue_item(KIND_APPEND, px[k], py[k], pz[k]);
    end
    repeat (3) queue_item(KIND_APPEND, any_coord(), any_coord(), any_coord());
    pick = $urandom_range(0, MAX_POINTS - 1);
    queue_item(KIND_QUERY, px[pick], py[pick], pz[pick]);
    // The last stored point sits at the end of the scan.
    queue_item(KIND_QUERY, px[MAX_POINTS - 1], py[MAX_POINTS - 1], pz[MAX_POINTS - 1]);
    pick = $urandom_range(0, MAX_POINTS - 1);
    queue_item(KIND_QUERY, nudge(px[pick], 2000), nudge(py[pick], 2000),
               nudge(pz[pick], 2000));
    queue_item(KIND_QUERY, any_coord(), any_coord(), any_coord());
    queue_item(KIND_UNUSED, any_coord(), any_coord(), any_coord());
    queue_item(KIND_CLEAR, 0, 0, 0);
    wait_drained();

    // Random part. Each phase sets a radius, usually starts from a clear store, loads a
    // cluster of points and then queries mostly near them, so that hits and misses mix.
    // A few items per phase are noise of any kind.
    random_done = 0;
    while (random_done < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       r_val = '0;
        1:       r_val = {28'h0, 36'hF_FFFF_FFFF};
        2:       r_val = {$urandom, $urandom};
        default: begin
          d = $urandom_range(0, 12000);
          r_val = PDATA_W'(d * d);
        end
      endcase
      program_radius(r_val);

      px.delete();
      py.delete();
      pz.delete();
      if (stored_n > 200 || $urandom_range(0, 3) != 0) begin
        queue_item(KIND_CLEAR, any_coord(), any_coord(), any_coord());
        random_done++;
      end
      cx = any_coord();
      cy = any_coord();
      cz = any_coord();
      case ($urandom_range(0, 3))
        0:       spread = 64;
        1:       spread = 1024;
        2:       spread = 6000;
        default: spread = 32768;
      endcase
      n_app = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
      for (int k = 0; k < n_app; k++) begin
        px.push_back(nudge(cx, spread));
        py.push_back(nudge(cy, spread));
        pz.push_back(nudge(cz, spread));
        queue_item(KIND_APPEND, px[k], py[k], pz[k]);
      end
      n_q = $urandom_range(1, 12);
      for (int k = 0; k < n_q; k++) begin
        case ($urandom_range(0, 9))
          0: begin
            queue_item(KIND_W'($urandom_range(0, 3)), any_coord(), any_coord(), any_coord());
          end
          1: begin
            queue_item(KIND_QUERY, any_coord(), any_coord(), any_coord());
          end
          default: begin
            if (px.size() == 0) begin
              queue_item(KIND_QUERY, nudge(cx, spread), nudge(cy, spread), nudge(cz, spread));
            end else begin
              pick = $urandom_range(0, px.size() - 1);
              case ($urandom_range(0, 3))
                0:       q_spread = 0;
                1:       q_spread = 256;
                2:       q_spread = 2048;
                default: q_spread = 6000;
              endcase
              queue_item(KIND_QUERY, nudge(px[pick], q_spread), nudge(py[pick], q_spread),
                         nudge(pz[pick], q_spread));
            end
          end
        endcase
      end
      random_done += n_app + n_q;
      wait_drained();
    end

    // Let any stray result show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (want_results.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", want_results.size()));
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/psrht_pkg.sv
hw/rtl/psrht_ram.sv
hw/rtl/psrht_ctrl.sv
hw/rtl/psrht_dp.sv
hw/rtl/point_set_radius_hit_test.sv
verif/tb_point_set_radius_hit_test.sv
